// ===== hdl/differential_drive_odometry_unit_assert.svh =====
// assertion macros for the odometry unit checker
// expects signals named clk and rst in the scope of use
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH

// same-cycle implication
`define ODO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ODO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/odo_pkg.sv =====
// shared types, constants and tables for the odometry unit
// no dependencies
package odo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_COUNT       = 24;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 10;

  localparam logic [CFG_IDX_W-1:0]  REG_TRACK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_PERIOD  = 2'd1;
  localparam logic [CFG_DATA_W-1:0] TRACK_RESET = 10'd149;
  localparam logic [CFG_DATA_W-1:0] PERIOD_RESET = 10'd50;

  // divider sizing: numerator magnitude below 2^59, denominator below 2^42
  localparam int DIV_NW = 60;
  localparam int DIV_DW = 43;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam int CS_W = 34;   // cordic x/y width, q30 plus headroom
  localparam int M_W  = 66;   // product register

  localparam logic [31:0] CORDIC_PRESCALE = 32'd652032874;
  localparam logic [31:0] TURN_CONST      = 32'd2799883369;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_COR_H0, OP_SAVE0, OP_COR_H1, OP_SAVE1,
    OP_MUL_SP, OP_MUL_DC, OP_MUL_DS, OP_DIV_STR, OP_TAKE_DX, OP_TAKE_DY,
    OP_MUL_DP, OP_MUL_TURN, OP_DIV_TRK, OP_TAKE_DH, OP_MUL_R, OP_DIV_DIF,
    OP_TAKE_R, OP_MUL_RS, OP_SHIFT_DX, OP_MUL_RC, OP_SHIFT_DY, OP_ACC,
    OP_PUBLISH
  } odo_op_t;

  typedef struct packed {
    odo_op_t op;
  } odo_cmd_t;

  typedef struct packed {
    logic straight;
    logic cor_done;
    logic div_done;
    logic out_free;
  } odo_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_COR0, S_WCOR0,
    S_ST_MD, S_ST_MC, S_ST_DX0, S_ST_DX1, S_ST_MS, S_ST_DY0, S_ST_DY1,
    S_AR_DP, S_AR_MT, S_AR_DH0, S_AR_DH1, S_AR_MR, S_AR_R0, S_AR_R1,
    S_COR1, S_WCOR1, S_AR_MX, S_AR_TX, S_AR_MY, S_AR_TY,
    S_ACC, S_PUB
  } odo_state_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/odo_if.sv =====
// channel interfaces of the odometry unit: items, results, configuration
// depends on odo_pkg
interface odo_item_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic signed [15:0] left_target;
  logic signed [15:0] right_target;
  modport source (output valid, operation, left_speed, right_speed, left_target,
                  right_target, input ready);
  modport sink (input valid, operation, left_speed, right_speed, left_target,
                right_target, output ready);
endinterface

interface odo_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading;
  logic               saturated;
  modport source (output valid, pos_x, pos_y, heading, saturated, input ready);
  modport sink (input valid, pos_x, pos_y, heading, saturated, output ready);
endinterface

interface odo_cfg_if import odo_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/odo_cordic.sv =====
// iterative rotation cordic, one micro-rotation per cycle
// depends on odo_pkg for the arctangent table
module odo_cordic import odo_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [15:0]            angle,
  output logic                   busy,
  output logic signed [CS_W-1:0] sin_q,
  output logic signed [CS_W-1:0] cos_q
);
  localparam int SW = $clog2(STEPS + 1);

  logic signed [CS_W-1:0] cx, cy, sx, sy;
  logic signed [32:0]     cz, z0, za, at;
  logic                   neg;
  logic [SW-1:0]          cnt;

  always_comb begin
    z0 = 33'(signed'({angle, 16'h0000}));
    za = z0;
    if (z0 > 33'sd1073741824) begin
      za = z0 - 33'sd2147483648;
    end else if (z0 < -33'sd1073741824) begin
      za = z0 + 33'sd2147483648;
    end
    sx = cx >>> cnt;
    sy = cy >>> cnt;
    at = 33'(signed'({1'b0, atan_entry(5'(cnt))}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      cx   <= CS_W'(signed'({1'b0, CORDIC_PRESCALE}));
      cy   <= '0;
      cz   <= za;
      neg  <= (z0 > 33'sd1073741824) || (z0 < -33'sd1073741824);
    end else if (busy) begin
      if (cz >= 0) begin
        cx <= cx - sy;
        cy <= cy + sx;
        cz <= cz - at;
      end else begin
        cx <= cx + sy;
        cy <= cy - sx;
        cz <= cz + at;
      end
      cnt <= cnt + 1'b1;
      if (cnt == SW'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign cos_q = neg ? -cx : cx;
  assign sin_q = neg ? -cy : cy;
endmodule

// ===== hdl/odo_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
// depends on odo_pkg for its widths
module odo_div import odo_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              busy,
  output logic [DIV_NW-1:0] quo
);
  logic [DIV_NW-1:0] acc;
  logic [DIV_DW-1:0] rem, den_r;
  logic [DIV_DW:0]   trial, diff;
  logic              qbit;
  logic [DIV_CW-1:0] cnt;

  always_comb begin
    trial = {rem, acc[DIV_NW-1]};
    diff  = trial - {1'b0, den_r};
    qbit  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= '0;
      acc   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem <= qbit ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      acc <= {acc[DIV_NW-2:0], qbit};
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CW'(DIV_NW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quo = acc;
endmodule

// ===== hdl/odo_ctrl.sv =====
// sequencer for the odometry unit: walks one item through the datapath
// depends on odo_pkg
module odo_ctrl import odo_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_clear,
  output logic      in_ready,
  input  odo_stat_t stat,
  output odo_cmd_t  cmd
);
  odo_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = in_clear ? S_PUB : S_COR0;
        end
      end
      S_COR0: begin
        cmd.op = OP_COR_H0;
        state_next = S_WCOR0;
      end
      S_WCOR0: begin
        if (stat.cor_done) begin
          cmd.op = OP_SAVE0;
          state_next = stat.straight ? S_ST_MD : S_AR_DP;
        end
      end
      S_ST_MD: begin
        cmd.op = OP_MUL_SP;
        state_next = S_ST_MC;
      end
      S_ST_MC: begin
        cmd.op = OP_MUL_DC;
        state_next = S_ST_DX0;
      end
      S_ST_DX0: begin
        cmd.op = OP_DIV_STR;
        state_next = S_ST_DX1;
      end
      S_ST_DX1: begin
        if (stat.div_done) begin
          cmd.op = OP_TAKE_DX;
          state_next = S_ST_MS;
        end
      end
      S_ST_MS: begin
        cmd.op = OP_MUL_DS;
        state_next = S_ST_DY0;
      end
      S_ST_DY0: begin
        cmd.op = OP_DIV_STR;
        state_next = S_ST_DY1;
      end
      S_ST_DY1: begin
        if (stat.div_done) begin
          cmd.op = OP_TAKE_DY;
          state_next = S_ACC;
        end
      end
      S_AR_DP: begin
        cmd.op = OP_MUL_DP;
        state_next = S_AR_MT;
      end
      S_AR_MT: begin
        cmd.op = OP_MUL_TURN;
        state_next = S_AR_DH0;
      end
      S_AR_DH0: begin
        cmd.op = OP_DIV_TRK;
        state_next = S_AR_DH1;
      end
      S_AR_DH1: begin
        if (stat.div_done) begin
          cmd.op = OP_TAKE_DH;
          state_next = S_AR_MR;
        end
      end
      S_AR_MR: begin
        cmd.op = OP_MUL_R;
        state_next = S_AR_R0;
      end
      S_AR_R0: begin
        cmd.op = OP_DIV_DIF;
        state_next = S_AR_R1;
      end
      S_AR_R1: begin
        if (stat.div_done) begin
          cmd.op = OP_TAKE_R;
          state_next = S_COR1;
        end
      end
      S_COR1: begin
        cmd.op = OP_COR_H1;
        state_next = S_WCOR1;
      end
      S_WCOR1: begin
        if (stat.cor_done) begin
          cmd.op = OP_SAVE1;
          state_next = S_AR_MX;
        end
      end
      S_AR_MX: begin
        cmd.op = OP_MUL_RS;
        state_next = S_AR_TX;
      end
      S_AR_TX: begin
        cmd.op = OP_SHIFT_DX;
        state_next = S_AR_MY;
      end
      S_AR_MY: begin
        cmd.op = OP_MUL_RC;
        state_next = S_AR_TY;
      end
      S_AR_TY: begin
        cmd.op = OP_SHIFT_DY;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        state_next = S_PUB;
      end
      S_PUB: begin
        if (stat.out_free) begin
          cmd.op = OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

// ===== hdl/odo_datapath.sv =====
// odometry datapath: pose registers, multiplier, cordic, divider, result register
// depends on odo_pkg, odo_cordic and odo_div
module odo_datapath import odo_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  odo_cmd_t              cmd,
  output odo_stat_t             stat,
  input  logic                  operation,
  input  logic signed [15:0]    left_speed,
  input  logic signed [15:0]    right_speed,
  input  logic signed [15:0]    left_target,
  input  logic signed [15:0]    right_target,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    pos_x,
  output logic signed [31:0]    pos_y,
  output logic [15:0]           heading,
  output logic                  saturated
);
  localparam logic signed [36:0] X_MAX = 37'sd2147483647;
  localparam logic signed [36:0] X_MIN = -37'sd2147483648;
  // ceil(2^35 / 125), exact quotient for dividends below 2^28
  localparam logic [28:0]        RECIP_125 = 29'd274877907;
  localparam logic [M_W-1:0]     STR_HALF  = M_W'(125) << 29;

  logic [CFG_DATA_W-1:0]  track, period, trk;
  logic signed [31:0]     x_acc, y_acc, r;
  logic [15:0]            heading_acc, h1;
  logic signed [16:0]     sum, dif;
  logic                   straight, sat, div_neg;
  logic signed [27:0]     d;
  logic signed [CS_W-1:0] s0, c0, s1, c1, cor_s, cor_c;
  logic signed [M_W-1:0]  m;
  logic signed [35:0]     dx, dy;

  logic                   cor_start, cor_busy, div_start, div_busy;
  logic [15:0]            cor_ang;
  logic [DIV_NW-1:0]      div_num, quo;
  logic [DIV_DW-1:0]      div_den;

  logic signed [27:0]     p_sp, p_dp;
  logic signed [61:0]     p_dc, p_ds;
  logic signed [60:0]     p_turn;
  logic signed [27:0]     p_ts;
  logic signed [M_W-1:0]  p_r, p_rs, p_rc;
  logic [M_W-1:0]         m_mag;
  logic [35:0]            sh_q;
  logic signed [35:0]     sh_val, q_sgn;
  logic signed [36:0]     x_sum, y_sum;
  logic [15:0]            dh;
  logic [16:0]            dif_mag;
  logic [27:0]            st_t;
  logic [56:0]            st_prod;
  logic [21:0]            st_q;

  assign trk = (track == '0) ? CFG_DATA_W'(1) : track;

  always_comb begin
    p_sp   = sum * signed'({1'b0, period});
    p_dp   = dif * signed'({1'b0, period});
    p_dc   = d * c0;
    p_ds   = d * s0;
    p_turn = signed'(m[27:0]) * signed'({1'b0, TURN_CONST});
    p_ts   = signed'({1'b0, trk}) * sum;
    p_r    = M_W'(dif[16] ? -p_ts : p_ts) <<< 7;
    p_rs   = r * (35'(s1) - 35'(s0));
    p_rc   = r * (35'(c0) - 35'(c1));
    m_mag  = m[M_W-1] ? M_W'(-m) : M_W'(m);
    // rounded shift by 30, halves away from zero
    sh_q   = 36'((m_mag + M_W'(1 << 29)) >> 30);
    sh_val = m[M_W-1] ? -signed'(sh_q) : signed'(sh_q);
    // straight step: divide by 125 through a reciprocal multiply
    st_prod = st_t * RECIP_125;
    st_q    = st_prod[56:35];
    q_sgn  = div_neg ? -signed'({14'd0, st_q}) : signed'({14'd0, st_q});
    dh     = div_neg ? 16'(-quo[15:0]) : quo[15:0];
    dif_mag = dif[16] ? 17'(-dif) : 17'(dif);
    x_sum  = 37'(x_acc) + 37'(dx);
    y_sum  = 37'(y_acc) + 37'(dy);

    div_den = '0;
    case (cmd.op)
      OP_DIV_TRK: div_den = DIV_DW'(trk) << 32;
      OP_DIV_DIF: div_den = DIV_DW'(dif_mag);
      default:    div_den = '0;
    endcase
    div_num   = m_mag[DIV_NW-1:0] + DIV_NW'(div_den >> 1);
    div_start = (cmd.op == OP_DIV_TRK) || (cmd.op == OP_DIV_DIF);
    cor_start = (cmd.op == OP_COR_H0) || (cmd.op == OP_COR_H1);
    cor_ang   = (cmd.op == OP_COR_H1) ? h1 : heading_acc;
  end

  odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .angle(cor_ang),
    .busy(cor_busy), .sin_q(cor_s), .cos_q(cor_c)
  );

  odo_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      track  <= TRACK_RESET;
      period <= PERIOD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_TRACK) begin
        track <= cfg_data;
      end else if (cfg_index == REG_PERIOD) begin
        period <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_acc       <= '0;
      y_acc       <= '0;
      heading_acc <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.op == OP_PUBLISH) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          sat <= 1'b0;
          dx  <= '0;
          dy  <= '0;
          h1  <= heading_acc;
          sum <= 17'(left_speed) + 17'(right_speed);
          dif <= 17'(right_speed) - 17'(left_speed);
          straight <= (left_target == right_target) || (left_speed == right_speed);
          if (operation) begin
            x_acc       <= '0;
            y_acc       <= '0;
            heading_acc <= '0;
          end
        end
        OP_SAVE0: begin
          s0 <= cor_s;
          c0 <= cor_c;
        end
        OP_SAVE1: begin
          s1 <= cor_s;
          c1 <= cor_c;
        end
        OP_MUL_SP:   d <= p_sp;
        OP_MUL_DC:   m <= M_W'(p_dc);
        OP_MUL_DS:   m <= M_W'(p_ds);
        OP_MUL_DP:   m <= M_W'(p_dp);
        OP_MUL_TURN: m <= M_W'(p_turn);
        OP_MUL_R:    m <= p_r;
        OP_MUL_RS:   m <= p_rs;
        OP_MUL_RC:   m <= p_rc;
        OP_DIV_STR: begin
          div_neg <= m[M_W-1];
          // shift by 30 with a bias of half of 125 * 2^30 first, so the divide by 125 that follows rounds
          st_t    <= 28'((m_mag + STR_HALF) >> 30);
        end
        OP_DIV_TRK, OP_DIV_DIF: div_neg <= m[M_W-1];
        OP_TAKE_DX:  dx <= q_sgn;
        OP_TAKE_DY:  dy <= q_sgn;
        OP_TAKE_DH:  h1 <= heading_acc + dh;
        OP_TAKE_R: begin
          if (!div_neg && (quo > DIV_NW'(32'h7FFFFFFF))) begin
            r   <= 32'sh7FFFFFFF;
            sat <= 1'b1;
          end else if (div_neg && (quo > DIV_NW'(32'h80000000))) begin
            r   <= 32'sh80000000;
            sat <= 1'b1;
          end else begin
            r <= div_neg ? -signed'(quo[31:0]) : signed'(quo[31:0]);
          end
        end
        OP_SHIFT_DX: dx <= sh_val;
        OP_SHIFT_DY: dy <= sh_val;
        OP_ACC: begin
          heading_acc <= h1;
          if (x_sum > X_MAX) begin
            x_acc <= 32'sh7FFFFFFF;
          end else if (x_sum < X_MIN) begin
            x_acc <= 32'sh80000000;
          end else begin
            x_acc <= x_sum[31:0];
          end
          if (y_sum > X_MAX) begin
            y_acc <= 32'sh7FFFFFFF;
          end else if (y_sum < X_MIN) begin
            y_acc <= 32'sh80000000;
          end else begin
            y_acc <= y_sum[31:0];
          end
          if (x_sum > X_MAX || x_sum < X_MIN || y_sum > X_MAX || y_sum < X_MIN) begin
            sat <= 1'b1;
          end
        end
        OP_PUBLISH: begin
          pos_x     <= x_acc;
          pos_y     <= y_acc;
          heading   <= heading_acc;
          saturated <= sat;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    stat.straight = straight;
    stat.cor_done = !cor_busy;
    stat.div_done = !div_busy;
    stat.out_free = !out_valid || out_ready;
  end
endmodule

// ===== hdl/differential_drive_odometry_unit.sv =====
// Differential-drive dead-reckoning odometry unit, top level.
// Channels: items (sink) carries one update or clear command per beat, results
// (source) returns the pose after each item, cfg (sink) writes wheel track
// (index 0) and update period (index 1); cfg is always ready.
// One item is in work at a time. A clear goes from the idle state straight to
// publishing; an update walks the sequencer states first, with one cordic pass
// for a straight update and two for an arc, at 16 cordic steps by default; the
// straight step divides by a reciprocal multiply, and the arc runs the bit-serial
// divider twice (turn and radius).
// The result sits in an output register; a new item is taken while it waits,
// but the next result is held back until the receiver takes the previous one,
// and no further item is taken meanwhile.
// Reset (synchronous) zeroes the pose, loads track 149 mm and period 50 ms,
// and drops results.valid.
// depends on odo_pkg, odo_if, odo_ctrl, odo_datapath
module differential_drive_odometry_unit import odo_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  odo_item_if.sink     items,
  odo_result_if.source results,
  odo_cfg_if.sink      cfg
);
  odo_cmd_t  cmd;
  odo_stat_t stat;

  assign cfg.ready = 1'b1;

  odo_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(items.valid), .in_clear(items.operation),
    .in_ready(items.ready), .stat(stat), .cmd(cmd)
  );

  odo_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .operation(items.operation), .left_speed(items.left_speed),
    .right_speed(items.right_speed), .left_target(items.left_target),
    .right_target(items.right_target),
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .out_valid(results.valid), .out_ready(results.ready),
    .pos_x(results.pos_x), .pos_y(results.pos_y), .heading(results.heading),
    .saturated(results.saturated)
  );
endmodule

// ===== hdl/odo_checker.sv =====
// port-level checker for the odometry unit, bound to the top level
// depends on differential_drive_odometry_unit_assert.svh
`include "differential_drive_odometry_unit_assert.svh"

module odo_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_clear,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pos_x,
  input logic [31:0] pos_y,
  input logic [15:0] heading,
  input logic        saturated
);
  logic [1:0] pending;
  logic       last_clear;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      last_clear <= 1'b0;
    end else begin
      pending <= pending + 2'(in_beat) - 2'(out_beat);
      if (in_beat) begin
        last_clear <= in_clear;
      end
    end
  end

  `ODO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `ODO_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(pos_x) && $stable(pos_y), "result changed while stalled")
  `ODO_ASSERT_NOW(a_no_extra, out_valid, pending != 2'd0, "result without an item")
  `ODO_ASSERT_NOW(a_clear_zero, out_valid && pending == 2'd1 && last_clear, pos_x == 32'd0 && pos_y == 32'd0 && heading == 16'd0 && !saturated, "clear did not zero the pose")
endmodule

bind differential_drive_odometry_unit odo_port_checker u_odo_port_checker (
  .clk(clk), .rst(rst),
  .in_valid(items.valid), .in_ready(items.ready), .in_clear(items.operation),
  .out_valid(results.valid), .out_ready(results.ready),
  .pos_x(results.pos_x), .pos_y(results.pos_y), .heading(results.heading),
  .saturated(results.saturated)
);
